[sv/bat_pkg.sv]
package bat_pkg;

    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    // request kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END  = 1'd1;

    typedef struct packed {
        logic load;       // capture request, clear scan state
        logic scan_step;  // issue one table read
        logic commit;     // form result, append on a good add
    } bat_cmd_t;

    typedef struct packed {
        logic early_done; // no scan needed
        logic scan_last;  // current read is the last stored entry
        logic out_free;   // output register can take a result
    } bat_sts_t;

endpackage

[sv/bat_ctrl.sv]
module bat_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bat_pkg::bat_sts_t sts,
    output bat_pkg::bat_cmd_t cmd
);
    import bat_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = sts.early_done ? S_FINISH : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last read data is compared at this edge
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/bat_dpath.sv]
module bat_dpath
#(
    parameter int CAPACITY = 256
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bat_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bat_pkg::ADDR_W-1:0]      cfg_data,
    input  logic                            kind,
    input  logic [bat_pkg::ADDR_W-1:0]      addr,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bat_pkg::STATUS_W-1:0]    status,
    output logic                            hit,
    input  bat_pkg::bat_cmd_t               cmd,
    output bat_pkg::bat_sts_t               sts
);
    import bat_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [ADDR_W-1:0]   mem [CAPACITY];

    logic [ADDR_W-1:0]   base_reg;
    logic [ADDR_W-1:0]   end_reg;
    logic [CW-1:0]       count_reg;
    logic                kind_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [AW-1:0]       idx_reg;
    logic                rd_vld_reg;
    logic [ADDR_W-1:0]   rd_data_reg;
    logic                match_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                hit_reg;

    logic                invalid;
    logic                full;
    logic                append;
    logic [STATUS_W-1:0] status_next;

    assign invalid = (addr_reg < base_reg) || (addr_reg >= end_reg) ||
                     (addr_reg[1:0] != 2'b00);
    assign full    = (count_reg >= CW'(CAPACITY));

    assign sts.early_done = (count_reg == '0) ||
                            ((kind_reg == KIND_ADD) && (invalid || full));
    assign sts.scan_last  = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        append      = 1'b0;
        status_next = ST_OK;
        if (kind_reg == KIND_ADD)
        begin
            if (invalid)
            begin
                status_next = ST_INVALID;
            end
            else if (full)
            begin
                status_next = ST_FULL;
            end
            else if (match_reg)
            begin
                status_next = ST_DUP;
            end
            else
            begin
                append = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            end_reg  <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_BASE: base_reg <= cfg_data;
                REG_WINDOW_END:  end_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            match_reg     <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_step;
            if (cmd.load)
            begin
                match_reg <= 1'b0;
            end
            else if (rd_vld_reg && (rd_data_reg == addr_reg))
            begin
                match_reg <= 1'b1;
            end
            if (cmd.commit && append)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            addr_reg <= addr;
        end
        if (cmd.load)
        begin
            idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[idx_reg];
        end
        if (cmd.commit && append)
        begin
            mem[count_reg[AW-1:0]] <= addr_reg;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            hit_reg    <= (kind_reg == KIND_CHECK) && match_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign hit       = hit_reg;

endmodule

[sv/breakpoint_address_table_core.sv]
// Sequence: an accepted request passes EVAL, then SCAN (one table read per cycle through
// the single memory port, one read per stored entry), DRAIN and FINISH, where the result
// is committed to the output register; with no scan needed EVAL goes straight to FINISH.
// One request in flight; a finished result waits in the output register while the next
// request runs, and that request's result stalls until the first is taken.
// Reset: entry count cleared, window_base 0, window_end all ones; table contents undefined.
module breakpoint_address_table_core
#(
    parameter int CAPACITY = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bat_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [bat_pkg::ADDR_W-1:0]    addr,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bat_pkg::STATUS_W-1:0]  status,
    output logic                          hit
);
    import bat_pkg::*;

    bat_cmd_t cmd;
    bat_sts_t sts;

    bat_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bat_dpath #(.CAPACITY(CAPACITY)) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kind      (kind),
        .addr      (addr),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .hit       (hit),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while busy");

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || out_ready))
        else $error("result would overwrite an untaken result");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan_step, cmd.commit}))
        else $error("conflicting datapath commands");

    a_hit_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (status == ST_OK))
        else $error("hit with non-ok status");

endmodule
